/* hdl/frame_history_stacker_macros.svh */
// ----------------------------------------------------------------------------
// Frame history stacker assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAME_HISTORY_STACKER_MACROS_SVH
`define FRAME_HISTORY_STACKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define FHS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("frame history stacker check failed");
// next-cycle implication, disabled during reset
`define FHS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("frame history stacker check failed");
`else
`define FHS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define FHS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

/* hdl/fhs_pkg.sv */
// ----------------------------------------------------------------------------
// Frame history stacker package
// Shared codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package fhs_pkg;

  localparam int FRAMES_MAX_DEF = 15;
  localparam int ELEMS_MAX_DEF  = 64;

  localparam int SAMPLE_W  = 32;
  localparam int FUNC_W    = 2;
  localparam int FPOS_W    = 4;
  localparam int EPOS_W    = 6;
  localparam int STATUS_W  = 2;
  localparam int HELD_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // default RAM geometry: slots x elements, address is {slot, element}
  localparam int RAM_AW_DEF = $clog2(FRAMES_MAX_DEF + 1) + $clog2(ELEMS_MAX_DEF);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_LENGTH    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAMES_IN_USE = 2'd0,
    CFG_FRAME_LENGTH  = 2'd1,
    CFG_STACK_ORDER   = 2'd2,
    CFG_PAD_MODE      = 2'd3
  } cfg_idx_t;

endpackage

/* hdl/fhs_ram.sv */
// ----------------------------------------------------------------------------
// Frame store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fhs_ram #(
  parameter int ADDR_W = fhs_pkg::RAM_AW_DEF,
  parameter int DATA_W = fhs_pkg::SAMPLE_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  import fhs_pkg::*;

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/frame_history_stacker.sv */
// ----------------------------------------------------------------------------
// Frame history stacker
// Ring store of the last N observation frames with stacked-vector readout.
// ----------------------------------------------------------------------------
// One transfer on the input stream is one operation, chosen by s_tuser:
// push a sample (s_tlast marks the last sample of a frame), read one element
// of the stacked history, clear the history, or do nothing. Every transfer
// gives exactly one result transfer on the output stream, in order. The
// block takes one transfer per clock cycle when the output side keeps up;
// the transfer registers the synchronous frame store read and the result's
// status in the second stage, which then loads the output register once
// that register is free, raising m_tvalid. Frames live in a single RAM of
// FRAMES_MAX+1 slots, each of 2**ceil(log2(ELEMS_MAX)) words; the slot after
// the newest frame collects the frame being received, so a frame of the
// wrong length never disturbs held frames. Write the configuration only
// while no result is outstanding. The RAM needs no clearing pass: only
// committed frames are ever read.
// ----------------------------------------------------------------------------
`include "frame_history_stacker_macros.svh"

module frame_history_stacker #(
  parameter int FRAMES_MAX = fhs_pkg::FRAMES_MAX_DEF,
  parameter int ELEMS_MAX  = fhs_pkg::ELEMS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [fhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhs_pkg::CFG_DAT_W-1:0]  cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,   // sample[31:0], frame_pos[35:32],
                                                    // elem_pos[41:36], zero fill
  input  logic [fhs_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
  input  logic                           s_tlast,   // frame_end
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // data[31:0], frames_held[35:32],
                                                    // zero fill
  output logic [2:0]                     m_tuser    // status[1:0], is_padding[2]
);
  import fhs_pkg::*;

  localparam int SLOTS = FRAMES_MAX + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int EW    = (ELEMS_MAX > 1) ? $clog2(ELEMS_MAX) : 1;
  localparam int AW    = SW + EW;
  localparam int HW    = $clog2(FRAMES_MAX + 1);
  localparam int FW    = $clog2(ELEMS_MAX + 1);

  // configuration registers
  logic [FPOS_W-1:0] frames_in_use;
  logic [6:0]        frame_length;
  logic              stack_order;
  logic              pad_mode;

  // history state
  logic [SW-1:0] newest_slot, newest_slot_next;
  logic [HW-1:0] held_count, held_count_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic          overrun_flag, overrun_flag_next;

  // unpacked input fields
  func_t             func;
  logic [SAMPLE_W-1:0] sample;
  logic [FPOS_W-1:0] frame_pos;
  logic [EPOS_W-1:0] elem_pos;

  assign func      = func_t'(s_tuser);
  assign sample    = s_tdata[31:0];
  assign frame_pos = s_tdata[35:32];
  assign elem_pos  = s_tdata[41:36];

  // effective sizes after clamping
  logic [HELD_W-1:0] eff_n;
  logic [FW-1:0]     eff_len;
  logic [HELD_W-1:0] eff_held;

  always_comb begin
    if (frames_in_use == '0) begin
      eff_n = HELD_W'(1);
    end else if (int'(frames_in_use) > FRAMES_MAX) begin
      eff_n = HELD_W'(FRAMES_MAX);
    end else begin
      eff_n = frames_in_use;
    end
    if (frame_length == '0) begin
      eff_len = FW'(1);
    end else if (int'(frame_length) > ELEMS_MAX) begin
      eff_len = FW'(ELEMS_MAX);
    end else begin
      eff_len = FW'(frame_length);
    end
    if (int'(held_count) < int'(eff_n)) begin
      eff_held = HELD_W'(held_count);
    end else begin
      eff_held = eff_n;
    end
  end

  // pipeline control
  logic    accept;
  logic    s2_valid;
  logic    s2_move;
  status_t s2_status;
  logic    s2_pad;
  logic    s2_use_mem;

  // a pending result advances once the output register is free
  assign s2_move  = s2_valid && (!m_tvalid || m_tready);
  assign s_tready = !s2_valid || s2_move;
  assign accept   = s_tvalid && s_tready;

  // operation decode
  logic [SW-1:0]     stage_slot;
  logic [FW-1:0]     fill_plus;
  logic              room;
  logic              range_err;
  logic [FPOS_W-1:0] col;
  logic [FPOS_W-1:0] missing;
  logic              is_pad;
  logic [FPOS_W-1:0] age;
  logic [SW-1:0]     rd_slot;
  logic              ram_we;
  logic              ram_re;
  status_t           status_d;
  logic              use_mem_d;
  logic [SAMPLE_W-1:0] rdata;

  always_comb begin
    stage_slot = (int'(newest_slot) == SLOTS - 1) ? '0 : newest_slot + 1'b1;
    fill_plus  = fill_count + 1'b1;
    room       = fill_count < eff_len;
    range_err  = (frame_pos >= eff_n) || (int'(elem_pos) >= int'(eff_len));
    // position in oldest-first order
    col        = stack_order ? (eff_n - 4'd1 - frame_pos) : frame_pos;
    missing    = eff_n - eff_held;
    is_pad     = col < missing;
    // padding replicates the oldest held frame
    age        = is_pad ? (eff_held - 4'd1) : (eff_n - 4'd1 - col);
    if (int'(newest_slot) >= int'(age)) begin
      rd_slot = newest_slot - SW'(age);
    end else begin
      rd_slot = SW'(int'(newest_slot) + SLOTS - int'(age));
    end

    newest_slot_next  = newest_slot;
    held_count_next   = held_count;
    fill_count_next   = fill_count;
    overrun_flag_next = overrun_flag;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    status_d          = ST_OK;
    use_mem_d         = 1'b0;

    case (func)
      FUNC_PUSH: begin
        ram_we = accept && room;
        if (s_tlast) begin
          if (overrun_flag || !room || (fill_plus != eff_len)) begin
            status_d = ST_LENGTH;
          end else begin
            newest_slot_next = stage_slot;
            if (int'(held_count) < int'(eff_n)) begin
              held_count_next = held_count + 1'b1;
            end else begin
              held_count_next = HW'(eff_n);
            end
          end
          fill_count_next   = '0;
          overrun_flag_next = 1'b0;
        end else if (room) begin
          fill_count_next = fill_plus;
        end else begin
          overrun_flag_next = 1'b1;
        end
      end
      FUNC_READ: begin
        if (range_err) begin
          status_d = ST_RANGE;
        end else if (eff_held == '0) begin
          status_d = ST_EMPTY;
        end else begin
          use_mem_d = !(is_pad && pad_mode);
        end
        ram_re = accept && use_mem_d;
      end
      FUNC_CLEAR: begin
        held_count_next   = '0;
        fill_count_next   = '0;
        overrun_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  fhs_ram #(
    .ADDR_W (AW),
    .DATA_W (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({stage_slot, EW'(fill_count)}),
    .wdata (sample),
    .re    (ram_re),
    .raddr ({rd_slot, EW'(elem_pos)}),
    .rdata (rdata)
  );

  // configuration writes; indexes beyond the list do not exist
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FPOS_W'(1);
      frame_length  <= 7'd1;
      stack_order   <= 1'b0;
      pad_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAMES_IN_USE: frames_in_use <= cfg_data[FPOS_W-1:0];
        CFG_FRAME_LENGTH:  frame_length  <= cfg_data;
        CFG_STACK_ORDER:   stack_order   <= cfg_data[0];
        CFG_PAD_MODE:      pad_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // history state advances on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot  <= SW'(SLOTS - 1);
      held_count   <= '0;
      fill_count   <= '0;
      overrun_flag <= 1'b0;
    end else if (accept) begin
      newest_slot  <= newest_slot_next;
      held_count   <= held_count_next;
      fill_count   <= fill_count_next;
      overrun_flag <= overrun_flag_next;
    end
  end

  // second stage: wait for the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_status  <= status_d;
      s2_pad     <= (status_d == ST_OK) && (func == FUNC_READ) && is_pad;
      s2_use_mem <= use_mem_d;
    end
  end

  // output register; frames held is taken after the item's own update
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      m_tdata[31:0]  <= s2_use_mem ? rdata : '0;
      m_tdata[35:32] <= eff_held;
      m_tdata[39:36] <= '0;
      m_tuser[1:0]   <= s2_status;
      m_tuser[2]     <= s2_pad;
    end
  end

  // checks
  `FHS_ASSERT_IMP(a_held_bound, clk, rst, 1'b1, int'(held_count) <= FRAMES_MAX)
  `FHS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, int'(fill_count) <= ELEMS_MAX)
  `FHS_ASSERT_IMP(a_no_overtake, clk, rst, s2_valid && !s2_move, !s_tready)
  `FHS_ASSERT_IMP(a_err_zero, clk, rst, m_tvalid && (m_tuser[1:0] != ST_OK), m_tdata[31:0] == '0)

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame history stacker testbench
// Drives pushes, stacked-history reads, clears and no-ops through the input
// stream under several register settings and idle patterns. A behavioural
// copy of the history store predicts every result; the output stream is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fhs_pkg::*;

  localparam int SLOTS      = FRAMES_MAX_DEF + 1;
  localparam int ELEMS      = ELEMS_MAX_DEF;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [31:0] data;
    status_t     status;
    logic        pad;
    logic [3:0]  held;
  } stack_result_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;   // sample[31:0], frame_pos[35:32], elem_pos[41:36]
  logic [1:0]  s_tuser   = '0;   // func[1:0]
  logic        s_tlast   = 1'b0; // frame_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // data[31:0], frames_held[35:32]
  logic [2:0]  m_tuser;          // status[1:0], is_padding[2]

  frame_history_stacker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // History model: ring of frames, staging slot after the newest one
  // --------------------------------------------------------------------------
  logic [31:0]  hist_store [SLOTS][ELEMS];
  int unsigned  newest_slot = SLOTS - 1;
  int unsigned  held_cnt    = 0;
  int unsigned  fill_cnt    = 0;
  bit           overrun     = 1'b0;

  logic [3:0]   reg_frames  = 4'd1;
  logic [6:0]   reg_length  = 7'd1;
  logic         reg_order   = 1'b0;
  logic         reg_pad     = 1'b0;

  stack_result_t expected_results[$];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  transfers_in  = 0;
  int unsigned  results_seen  = 0;
  int unsigned  commits       = 0;
  int unsigned  length_errs   = 0;
  int unsigned  pad_reads     = 0;
  int unsigned  frame_reads   = 0;

  function automatic int unsigned length_of(logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > ELEMS) return ELEMS;
    return 32'(raw);
  endfunction

  function automatic int unsigned depth_now();
    return (reg_frames == 0) ? 1 : 32'(reg_frames);
  endfunction

  function automatic int unsigned held_now();
    return (held_cnt < depth_now()) ? held_cnt : depth_now();
  endfunction

  function automatic logic [31:0] word_at_age(int unsigned age, int unsigned e);
    return hist_store[(newest_slot + SLOTS - (age % SLOTS)) % SLOTS][e];
  endfunction

  // Advance the history by one operation and return what the block must give
  function automatic stack_result_t step_history(func_t f, logic [31:0] smp, logic fe,
                                                 logic [3:0] fp, logic [5:0] ep);
    stack_result_t r;
    int unsigned   n;
    int unsigned   len;
    int unsigned   h;
    int unsigned   stage;
    int unsigned   col;
    r.data   = '0;
    r.status = ST_OK;
    r.pad    = 1'b0;
    n        = depth_now();
    len      = length_of(reg_length);
    case (f)
      FUNC_PUSH: begin
        stage = (newest_slot + 1) % SLOTS;
        if (fill_cnt >= len) begin
          overrun = 1'b1;   // drop the sample, fail the frame at its end
        end else begin
          hist_store[stage][fill_cnt] = smp;
          fill_cnt++;
        end
        if (fe) begin
          if (overrun || fill_cnt != len) begin
            r.status = ST_LENGTH;
            length_errs++;
          end else begin
            newest_slot = stage;
            if (held_cnt < n) held_cnt++;
            if (held_cnt > n) held_cnt = n;
            commits++;
          end
          fill_cnt = 0;
          overrun  = 1'b0;
        end
      end
      FUNC_READ: begin
        h = held_now();
        if (fp >= n || ep >= len) begin
          r.status = ST_RANGE;
        end else if (h == 0) begin
          r.status = ST_EMPTY;
        end else begin
          col = reg_order ? (n - 1 - fp) : fp;
          if (col < n - h) begin
            r.pad  = 1'b1;
            r.data = reg_pad ? 32'd0 : word_at_age(h - 1, ep);
            pad_reads++;
          end else begin
            r.data = word_at_age(n - 1 - col, ep);
            frame_reads++;
          end
        end
      end
      FUNC_CLEAR: begin
        held_cnt = 0;
        fill_cnt = 0;
        overrun  = 1'b0;
      end
      default: ;
    endcase
    r.held = 4'(held_now());
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------
  // Present one operation, hold it until the transfer, then predict its result
  task automatic send_op(func_t f, logic [31:0] smp, logic fe, logic [3:0] fp,
                         logic [5:0] ep);
    stack_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, ep, fp, smp};
    s_tuser  <= f;
    s_tlast  <= fe;
    do @(posedge clk); while (!s_tready);
    transfers_in++;
    res = step_history(f, smp, fe, fp, ep);
    expected_results = {expected_results, res};
  endtask

  // Push fields that the block ignores are randomised too
  task automatic push_sample(logic [31:0] smp, logic fe);
    send_op(FUNC_PUSH, smp, fe, 4'($urandom), 6'($urandom));
  endtask

  task automatic read_elem(logic [3:0] fp, logic [5:0] ep);
    send_op(FUNC_READ, $urandom, 1'($urandom), fp, ep);
  endtask

  task automatic push_frame(int unsigned count, bit with_end);
    for (int unsigned i = 0; i < count; i++)
      push_sample($urandom, with_end && (i == count - 1));
  endtask

  // Drop valid and wait for every outstanding result, plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers while idle. A longer frame would expose words of
  // held frames that were never written, so clear the history first then.
  task automatic set_config(logic [3:0] frames, logic [6:0] length, logic order,
                            logic pad);
    settle();
    if (length_of(length) > length_of(reg_length)) begin
      send_op(FUNC_CLEAR, $urandom, 1'b0, '0, '0);
      settle();
    end
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAMES_IN_USE;
    cfg_data  <= {3'd0, frames};
    reg_frames = frames;
    @(posedge clk);
    cfg_index <= CFG_FRAME_LENGTH;
    cfg_data  <= length;
    reg_length = length;
    @(posedge clk);
    cfg_index <= CFG_STACK_ORDER;
    cfg_data  <= {6'd0, order};
    reg_order  = order;
    @(posedge clk);
    cfg_index <= CFG_PAD_MODE;
    cfg_data  <= {6'd0, pad};
    reg_pad    = pad;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------
  // Reset settings: one frame of one sample, nothing held yet
  task automatic test_empty_history();
    read_elem(4'd0, 6'd0);    // empty
    read_elem(4'd1, 6'd0);    // frame position beyond N beats emptiness
    read_elem(4'd0, 6'd1);    // element beyond the frame length
    send_op(FUNC_NOP, 32'hFFFF_FFFF, 1'b1, 4'hF, 6'h3F);
    send_op(FUNC_CLEAR, 32'h0, 1'b0, 4'h0, 6'h0);
  endtask

  // One held frame of three: the missing two replicate the oldest frame
  task automatic test_first_frame_replication();
    set_config(4'd3, 7'd4, 1'b0, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'hAAAA_AAAA, 1'b1);
    read_elem(4'd0, 6'd0);
    read_elem(4'd1, 6'd1);
    read_elem(4'd2, 6'd3);
  endtask

  // Short frame, overlong frame, and a partial frame dropped by a clear
  task automatic test_length_errors();
    push_frame(2, 1'b1);
    push_frame(5, 1'b1);
    push_frame(2, 1'b0);
    send_op(FUNC_CLEAR, $urandom, 1'b1, 4'($urandom), 6'($urandom));
  endtask

  // Newest-first order with zero padding
  task automatic test_order_and_zero_pad();
    set_config(4'd3, 7'd4, 1'b1, 1'b1);
    push_frame(4, 1'b1);
    read_elem(4'd0, 6'd2);    // newest frame
    read_elem(4'd2, 6'd2);    // padding, zero
  endtask

  // Lower N below the held count, then the register extremes
  task automatic test_depth_and_extremes();
    push_frame(4, 1'b1);
    set_config(4'd1, 7'd4, 1'b0, 1'b0);
    read_elem(4'd0, 6'd3);
    set_config(4'd0, 7'd0, 1'b0, 1'b1);   // both act as one
    push_sample($urandom, 1'b1);
    read_elem(4'd0, 6'd0);
    set_config(4'd15, 7'd127, 1'b1, 1'b0); // length acts as the maximum
    read_elem(4'd15, 6'd63);
    read_elem(4'd14, 6'd63);
  endtask

  // Random settings; mostly whole frames and in-range reads, some broken
  // frames, stray positions, clears and no-ops
  task automatic test_random_traffic(int unsigned items);
    int unsigned sent;
    int unsigned seg_end;
    int unsigned len;
    int unsigned k;
    logic [6:0]  length;
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(99);
      if (k < 70)      length = 7'($urandom_range(1, 8));
      else if (k < 78) length = 7'd0;
      else if (k < 86) length = 7'($urandom_range(64, 127));
      else             length = 7'($urandom_range(9, 63));
      set_config(4'($urandom), length, 1'($urandom), 1'($urandom));
      len     = length_of(reg_length);
      seg_end = sent + $urandom_range(40, 90);
      while (sent < seg_end && sent < items) begin
        k = $urandom_range(99);
        if (k < 40) begin
          push_frame(len, 1'b1);
          sent += len;
        end else if (k < 46) begin
          k = $urandom_range(2);
          if (k == 0 && len > 1) begin
            push_frame($urandom_range(1, len - 1), 1'b1);
            sent += 1;
          end else if (k == 1) begin
            push_frame(len + $urandom_range(1, 2), 1'b1);
            sent += len + 1;
          end else begin
            push_frame($urandom_range(1, len), 1'b0);
            sent += 1;
          end
        end else if (k < 90) begin
          read_elem(($urandom_range(99) < 85) ? 4'($urandom_range(0, depth_now() - 1))
                                              : 4'($urandom),
                    ($urandom_range(99) < 85) ? 6'($urandom_range(0, len - 1))
                                              : 6'($urandom));
          sent++;
        end else if (k < 94) begin
          send_op(FUNC_CLEAR, $urandom, 1'($urandom), 4'($urandom), 6'($urandom));
          sent++;
        end else begin
          send_op(func_t'($urandom_range(3)), $urandom, 1'($urandom), 4'($urandom),
                  6'($urandom));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic note_mismatch(string what, stack_result_t want, stack_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORT) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected data %h status %s pad %b held %0d",
               want.data, want.status.name(), want.pad, want.held);
      $display("  actual   data %h status %s pad %b held %0d",
               got.data, got.status.name(), got.pad, got.held);
    end
  endtask

  always @(posedge clk) begin : result_check
    stack_result_t got;
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.data   = m_tdata[31:0];
      got.held   = m_tdata[35:32];
      got.status = status_t'(m_tuser[1:0]);
      got.pad    = m_tuser[2];
      results_seen++;
      if (expected_results.size() == 0) begin
        want = '0;
        note_mismatch("result transfer with nothing outstanding", want, got);
      end else begin
        want = expected_results.pop_front();
        if (got.data !== want.data || got.status !== want.status ||
            got.pad !== want.pad || got.held !== want.held)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 82;
    test_empty_history();
    test_first_frame_replication();
    test_length_errors();
    test_order_and_zero_pad();
    test_depth_and_extremes();
    test_random_traffic(340);

    send_idle_pct = 82;
    recv_idle_pct = 24;
    test_random_traffic(340);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(340);

    settle();
    repeat (8) @(posedge clk);
    mismatch_cnt += expected_results.size();

    $display("Covered %0d input transfers and %0d result transfers, %0d mismatches.",
             transfers_in, results_seen, mismatch_cnt);
    $display("Frames committed %0d, length errors %0d, padded reads %0d, stored reads %0d.",
             commits, length_errs, pad_reads, frame_reads);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/fhs_pkg.sv
hdl/fhs_ram.sv
hdl/frame_history_stacker.sv
verif/tb.sv
